// File: sv/uicc_pkg.sv
// Shared types and constants for the UDP/IP ones'-complement checksum block.
package uicc_pkg;

    // Widths of the configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE_UDP            = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ADDRESS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DESTINATION_ADDRESS = 2'd2;

    // Protocol number that the UDP pseudo-header carries.
    localparam logic [15:0] UDP_PROTOCOL_NUMBER = 16'd17;

    // Width of the unfolded sum of seven 16-bit words.
    localparam int WIDE_SUM_W = 19;

    // Message summary handed from the byte accumulator to the finishing stages.
    typedef struct packed {
        logic [15:0] sum;
        logic [15:0] count;
    } msg_sum_t;

endpackage

// File: sv/uicc_accum.sv
// Byte pairing, running ones'-complement sum and byte count for one message.
module uicc_accum
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_message,
    output logic               msg_valid,
    output uicc_pkg::msg_sum_t msg,
    input  logic               msg_ready
);

    logic [15:0]        running_sum_reg, running_sum_next;
    logic [7:0]         held_high_byte_reg, held_high_byte_next;
    logic               odd_phase_reg, odd_phase_next;
    logic [15:0]        byte_count_reg, byte_count_next;
    logic               msg_valid_reg, msg_valid_next;
    uicc_pkg::msg_sum_t msg_reg, msg_next;

    logic        accept;
    logic [15:0] count_inc;
    logic [15:0] word;
    logic [16:0] raw_add;
    logic [15:0] added;

    // The summary register frees up when the next stage takes it.
    assign in_ready = !msg_valid_reg || msg_ready;
    assign accept   = in_valid && in_ready;

    // One end-around-carry add. On a last byte in the even phase the word is
    // the byte padded with a zero low byte, which covers the odd-length case.
    assign count_inc = byte_count_reg + 16'd1;
    assign word      = odd_phase_reg ? {held_high_byte_reg, data_byte} : {data_byte, 8'h00};
    assign raw_add   = {1'b0, running_sum_reg} + {1'b0, word};
    assign added     = raw_add[16] ? (raw_add[15:0] + 16'd1) : raw_add[15:0];

    // Next state of the message accumulator and the summary register.
    always_comb
    begin
        running_sum_next    = running_sum_reg;
        held_high_byte_next = held_high_byte_reg;
        odd_phase_next      = odd_phase_reg;
        byte_count_next     = byte_count_reg;
        msg_valid_next      = msg_valid_reg && !msg_ready;
        msg_next            = msg_reg;
        if (accept)
        begin
            if (end_of_message)
            begin
                running_sum_next    = 16'd0;
                held_high_byte_next = 8'd0;
                odd_phase_next      = 1'b0;
                byte_count_next     = 16'd0;
                msg_valid_next      = 1'b1;
                msg_next.sum        = added;
                msg_next.count      = count_inc;
            end
            else
            begin
                byte_count_next = count_inc;
                if (odd_phase_reg)
                begin
                    running_sum_next = added;
                    odd_phase_next   = 1'b0;
                end
                else
                begin
                    held_high_byte_next = data_byte;
                    odd_phase_next      = 1'b1;
                end
            end
        end
    end

    // Control and accumulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg    <= 16'd0;
            held_high_byte_reg <= 8'd0;
            odd_phase_reg      <= 1'b0;
            byte_count_reg     <= 16'd0;
            msg_valid_reg      <= 1'b0;
        end
        else
        begin
            running_sum_reg    <= running_sum_next;
            held_high_byte_reg <= held_high_byte_next;
            odd_phase_reg      <= odd_phase_next;
            byte_count_reg     <= byte_count_next;
            msg_valid_reg      <= msg_valid_next;
        end
    end

    // Summary payload.
    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
    end

    assign msg_valid = msg_valid_reg;
    assign msg       = msg_reg;

endmodule

// File: sv/udp_ip_ones_complement_checksum.sv
// Top level of the UDP/IP ones'-complement checksum block.
// The block takes one message byte per cycle, back to back, unless the
// output stalls it, and pairs the bytes big-endian into 16-bit words that
// go into a running ones'-complement sum; a lone final byte is padded with
// a zero low byte. On the byte marked tlast it hands the sum and the byte
// count on, and the next message may start in the very next cycle. With
// mode_udp set, the pseudo-header (source and destination address, protocol
// 17 and the byte count modulo 65536) is added in a second stage, and a
// third stage folds the carries and complements. The path has three
// registers: the byte add, the seven-word pseudo-header sum and the carry
// fold. The user must write the configuration registers only while no
// message is in flight; the block itself does not enforce it.
module udp_ip_ones_complement_checksum
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [uicc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uicc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
    input  logic                             s_axis_tlast,  // end_of_message
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata   // [15:0] checksum,
                                                            // [31:16] message_length
);

    logic        mode_udp_reg;
    logic [31:0] source_address_reg;
    logic [31:0] destination_address_reg;

    logic               msg_valid;
    uicc_pkg::msg_sum_t msg;
    logic               msg_ready;

    logic                            wide_valid_reg, wide_valid_next;
    logic [uicc_pkg::WIDE_SUM_W-1:0] wide_sum_reg, wide_sum_next;
    logic [15:0]                     wide_count_reg;
    logic                            wide_ready;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] checksum_reg, checksum_next;
    logic [15:0] length_reg;
    logic        out_ready;

    logic [16:0] fold_once;
    logic [15:0] fold_twice;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_udp_reg            <= 1'b1;
            source_address_reg      <= 32'd0;
            destination_address_reg <= 32'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                uicc_pkg::CFG_MODE_UDP:            mode_udp_reg <= cfg_wr_data[0];
                uicc_pkg::CFG_SOURCE_ADDRESS:      source_address_reg <= cfg_wr_data;
                uicc_pkg::CFG_DESTINATION_ADDRESS: destination_address_reg <= cfg_wr_data;
                default:                           mode_udp_reg <= mode_udp_reg;
            endcase
        end
    end

    // Byte pairing and message accumulation.
    uicc_accum u_accum
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .data_byte      (s_axis_tdata),
        .end_of_message (s_axis_tlast),
        .msg_valid      (msg_valid),
        .msg            (msg),
        .msg_ready      (msg_ready)
    );

    // Stage two: sum of the message word and, in UDP mode, the pseudo-header words, unfolded.
    // Folding the wide sum twice gives the same value as a chain of
    // end-around-carry adds, zero included.
    assign out_ready  = !out_valid_reg || m_axis_tready;
    assign wide_ready = !wide_valid_reg || out_ready;
    assign msg_ready  = wide_ready;

    always_comb
    begin
        wide_valid_next = wide_valid_reg && !out_ready;
        wide_sum_next   = wide_sum_reg;
        if (msg_valid && wide_ready)
        begin
            wide_valid_next = 1'b1;
            if (mode_udp_reg)
            begin
                wide_sum_next = {3'd0, msg.sum}
                              + {3'd0, source_address_reg[31:16]}
                              + {3'd0, source_address_reg[15:0]}
                              + {3'd0, destination_address_reg[31:16]}
                              + {3'd0, destination_address_reg[15:0]}
                              + {3'd0, uicc_pkg::UDP_PROTOCOL_NUMBER}
                              + {3'd0, msg.count};
            end
            else
            begin
                wide_sum_next = {3'd0, msg.sum};
            end
        end
    end

    // Stage three: fold the carries back in and complement.
    assign fold_once  = {1'b0, wide_sum_reg[15:0]}
                      + {14'd0, wide_sum_reg[uicc_pkg::WIDE_SUM_W-1:16]};
    assign fold_twice = fold_once[15:0] + {15'd0, fold_once[16]};

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        checksum_next  = checksum_reg;
        if (wide_valid_reg && out_ready)
        begin
            out_valid_next = 1'b1;
            checksum_next  = ~fold_twice;
        end
    end

    // Valid flags of the finishing stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wide_valid_reg <= wide_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload of the finishing stages.
    always_ff @(posedge clk)
    begin
        wide_sum_reg <= wide_sum_next;
        checksum_reg <= checksum_next;
        if (msg_valid && wide_ready)
        begin
            wide_count_reg <= msg.count;
        end
        if (wide_valid_reg && out_ready)
        begin
            length_reg <= wide_count_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {length_reg, checksum_reg};

endmodule

// File: sv/uicc_checker.sv
// Port-level checks for the checksum block, bound to its top level.
module uicc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic last_accept;

    assign last_accept = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    // A result that waits keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    // A result that waits keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // With the result side empty, every stage drains, so input is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with an empty output");

    // A last byte accepted while the sink stays ready reaches the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (last_accept && m_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("result missing after last byte");

endmodule

bind udp_ip_ones_complement_checksum uicc_checker u_uicc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: bench/udp_ip_ones_complement_checksum_tb.sv
// Self-checking testbench for the UDP/IP ones'-complement checksum block.
`timescale 1ns / 1ps

module udp_ip_ones_complement_checksum_tb;

    // The index just past the last register; the block must ignore writes to it.
    localparam logic [uicc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // Cycles to let the finishing stages settle after the last result.
    localparam int PIPE_SETTLE_CYCLES = 8;

    // One checksum result as it appears on the result stream.
    typedef struct packed {
        logic [15:0] message_length;
        logic [15:0] checksum;
    } checksum_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [uicc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [uicc_pkg::CFG_DATA_W-1:0]  cfg_wr_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata;   // [7:0] data_byte
    logic                             s_axis_tlast;   // end_of_message
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [31:0]                      m_axis_tdata;   // [15:0] checksum,
                                                      // [31:16] message_length

    // Mirror of the configuration registers.
    logic        udp_mode;
    logic [31:0] source_ip;
    logic [31:0] dst_addr;

    // Mirror of the per-message accumulator.
    logic [15:0] word_sum;
    logic [7:0]  high_byte;
    logic        high_pending;
    logic [15:0] byte_total;

    // Checksums still owed by the block, oldest first.
    checksum_result_t pending_checksums[$];

    // Knobs of the stimulus and the result sink.
    bit          tx_idle;
    bit          rx_idle;
    int unsigned hold_off_cycles;

    // Run statistics.
    int unsigned error_count;
    int unsigned bytes_sent;
    int unsigned messages_sent;
    int unsigned results_checked;

    udp_ip_ones_complement_checksum i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Add two words with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[15:0] + {15'd0, wide[16]};
    endfunction

    function automatic void clear_accumulator();
        word_sum     = '0;
        high_byte    = '0;
        high_pending = 1'b0;
        byte_total   = '0;
    endfunction

    // Fold one accepted byte into the mirror; on the last byte queue the checksum.
    function automatic void absorb_byte(input logic [7:0] data, input logic last);
        logic [15:0]      folded;
        checksum_result_t owed;
        byte_total = byte_total + 16'd1;
        if (!high_pending)
        begin
            high_byte    = data;
            high_pending = 1'b1;
        end
        else
        begin
            word_sum     = ones_add(word_sum, {high_byte, data});
            high_pending = 1'b0;
        end
        if (last)
        begin
            folded = word_sum;
            // A lone final byte is the high half of a zero-padded word.
            if (high_pending)
                folded = ones_add(folded, {high_byte, 8'h00});
            if (udp_mode)
            begin
                folded = ones_add(folded, source_ip[31:16]);
                folded = ones_add(folded, source_ip[15:0]);
                folded = ones_add(folded, dst_addr[31:16]);
                folded = ones_add(folded, dst_addr[15:0]);
                folded = ones_add(folded, uicc_pkg::UDP_PROTOCOL_NUMBER);
                folded = ones_add(folded, byte_total);
            end
            owed.checksum       = ~folded;
            owed.message_length = byte_total;
            pending_checksums.push_back(owed);
            messages_sent++;
            clear_accumulator();
        end
    endfunction

    // Offer one byte, after a random gap when tx_idle is set, and wait until the block takes it.
    task automatic send_byte(input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        absorb_byte(data, last);
        bytes_sent++;
    endtask

    task automatic send_message(input int unsigned length);
        for (int unsigned i = 0; i < length; i++)
            send_byte(8'($urandom_range(0, 255)), i == length - 1);
    endtask

    task automatic release_input();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every owed checksum has come and the pipeline is empty.
    task automatic drain_results();
        while (pending_checksums.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write, with the mirror following it.
    task automatic write_register(input logic [uicc_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (index)
            uicc_pkg::CFG_MODE_UDP:            udp_mode  = value[0];
            uicc_pkg::CFG_SOURCE_ADDRESS:      source_ip = value;
            uicc_pkg::CFG_DESTINATION_ADDRESS: dst_addr  = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Address values weighted toward the extremes.
    function automatic logic [31:0] pick_address();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Messages with the reset configuration: UDP mode, both addresses zero.
    task automatic test_reset_defaults();
        tx_idle = 1'b0;
        send_byte(8'h45, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAB, 1'b1);
        send_byte(8'hFF, 1'b1);
        release_input();
    endtask

    // Plain header mode, including both zero representations and odd length.
    task automatic test_ip_header_mode();
        drain_results();
        write_register(uicc_pkg::CFG_MODE_UDP,
                       {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0, 1'b0});
        // All-zero words keep the sum at zero.
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // Sums that are a multiple of 0xFFFF read as 0xFFFF.
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        // Carry out of the top wraps around into bit zero.
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hAB, 1'b1);
        release_input();
    endtask

    // Pseudo-header with all-ones and mixed addresses; a write to the spare index is issued as well.
    task automatic test_pseudo_header_extremes();
        drain_results();
        write_register(uicc_pkg::CFG_MODE_UDP, 32'd1);
        write_register(uicc_pkg::CFG_SOURCE_ADDRESS, 32'hFFFF_FFFF);
        write_register(uicc_pkg::CFG_DESTINATION_ADDRESS, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        release_input();
        drain_results();
        write_register(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        write_register(uicc_pkg::CFG_SOURCE_ADDRESS, 32'h0000_0000);
        write_register(uicc_pkg::CFG_DESTINATION_ADDRESS, 32'h8000_0001);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        release_input();
    endtask

    // A message of several hundred bytes, so the byte count runs past one byte.
    task automatic test_long_message();
        drain_results();
        write_register(uicc_pkg::CFG_SOURCE_ADDRESS, $urandom);
        write_register(uicc_pkg::CFG_DESTINATION_ADDRESS, $urandom);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        send_message(300);
        release_input();
    endtask

    // The sink holds off for a long stretch while short messages keep coming.
    task automatic test_output_stall();
        drain_results();
        tx_idle         = 1'b0;
        rx_idle         = 1'b0;
        hold_off_cycles = 300;
        for (int i = 0; i < 40; i++)
            send_message($urandom_range(1, 3));
        release_input();
    endtask

    // Random messages over several register settings and idling patterns.
    task automatic test_random_messages();
        int unsigned phase_bytes;
        int unsigned length;
        for (int phase = 0; phase < 7; phase++)
        begin
            drain_results();
            write_register(uicc_pkg::CFG_MODE_UDP,
                           {31'($urandom), phase == 0 ? 1'b0 : 1'($urandom)});
            write_register(uicc_pkg::CFG_SOURCE_ADDRESS, pick_address());
            write_register(uicc_pkg::CFG_DESTINATION_ADDRESS, pick_address());
            tx_idle     = phase[0];
            rx_idle     = phase[1] | phase[2];
            phase_bytes = 0;
            while (phase_bytes < 130)
            begin
                length = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 120)
                                                     : $urandom_range(1, 16);
                send_message(length);
                phase_bytes += length;
                // Once, the sender stops until every result is back.
                if (phase == 3 && phase_bytes >= 65 && phase_bytes - length < 65)
                begin
                    release_input();
                    drain_results();
                end
            end
            release_input();
        end
    endtask

    // Result sink: random stalls per item when rx_idle is set, plus a long hold-off on request.
    initial
    begin : result_sink
        int unsigned pause;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            pause = rx_idle ? $urandom_range(0, 19) : 0;
            if (pause > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready) && hold_off_cycles == 0);
        end
    end

    // Compare each delivered result with the oldest owed checksum.
    always @(posedge clk)
    begin
        checksum_result_t owed;
        checksum_result_t seen;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = m_axis_tdata;
            if (pending_checksums.size() == 0)
            begin
                $error("unexpected result: checksum %h, message_length %0d",
                       seen.checksum, seen.message_length);
                error_count++;
            end
            else
            begin
                owed = pending_checksums.pop_front();
                if (seen.checksum !== owed.checksum)
                begin
                    $error("checksum: expected %h, actual %h", owed.checksum, seen.checksum);
                    error_count++;
                end
                if (seen.message_length !== owed.message_length)
                begin
                    $error("message_length: expected %0d, actual %0d",
                           owed.message_length, seen.message_length);
                    error_count++;
                end
            end
            results_checked++;
        end
    end

    // Run-time limit.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still owed", pending_checksums.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Test sequence.
    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= '0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        udp_mode        = 1'b1;
        source_ip       = '0;
        dst_addr        = '0;
        tx_idle         = 1'b0;
        rx_idle         = 1'b0;
        hold_off_cycles = 0;
        clear_accumulator();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_ip_header_mode();
        test_pseudo_header_extremes();
        test_long_message();
        test_output_stall();
        test_random_messages();
        drain_results();

        $display("Sent %0d bytes in %0d messages and checked %0d results.",
                 bytes_sent, messages_sent, results_checked);
        $display("Both checksum modes, extreme addresses, long messages and output stalls ran.");
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
